// ----- hdl/fis_pkg.sv -----
// Package for the frame interval statistics block: types, codes and constants.
// Used by fis_bucket_mem and frame_interval_statistics.
`timescale 1ns / 1ps
package fis_pkg;

   localparam int STAMP_W    = 63;
   localparam int IV_W       = 27;
   localparam int CNT_W      = 32;
   localparam int SUM_W      = 64;
   localparam int Q_W        = 17;
   localparam int BIDX_W     = 3;
   localparam int OP_W       = 2;
   localparam int BUCKETS    = 7;

   localparam logic [IV_W-1:0] MAX_INTERVAL = 27'd100000000;
   localparam logic [IV_W-1:0] BUDGET_RESET = 27'd16666667;

   localparam logic [OP_W-1:0] OP_STAMP  = 2'd0;
   localparam logic [OP_W-1:0] OP_PCTL   = 2'd1;
   localparam logic [OP_W-1:0] OP_BUCKET = 2'd2;

   localparam logic [1:0] CSR_BUDGET_ADDR = 2'd0;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ST1,
      S_ST2,
      S_ST3,
      S_P_MUL,
      S_P_RANK,
      S_P_PASS,
      S_P_SCAN,
      S_P_DECIDE,
      S_BQ_RD,
      S_BQ_DATA,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic [BIDX_W-1:0] addr;
      logic [CNT_W-1:0]  data;
   } bkt_wr_type;

   // Bucket edges are inclusive upper bounds; the last bucket takes the rest.
   function automatic logic [BIDX_W-1:0] bucket_of(input logic [IV_W-1:0] iv);
      logic [BIDX_W-1:0] b;
      if (iv <= 27'd8000000) begin
         b = 3'd0;
      end else if (iv <= 27'd12000000) begin
         b = 3'd1;
      end else if (iv <= 27'd15000000) begin
         b = 3'd2;
      end else if (iv <= 27'd16700000) begin
         b = 3'd3;
      end else if (iv <= 27'd20000000) begin
         b = 3'd4;
      end else if (iv <= 27'd33400000) begin
         b = 3'd5;
      end else begin
         b = 3'd6;
      end
      return b;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

// ----- hdl/fis_ring_mem.sv -----
// Ring of recent intervals: single-port write, single-port read with a registered read output.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
module fis_ring_mem #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 27
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fis_bucket_mem.sv -----
// Histogram bucket counters in a small memory with per-entry valid bits.
// Depends on fis_pkg; an entry never written since reset reads as zero.
`timescale 1ns / 1ps
module fis_bucket_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  fis_pkg::bkt_wr_type            wr,
   input  logic [fis_pkg::BIDX_W-1:0]     rd_addr,
   output logic [fis_pkg::CNT_W-1:0]      rd_data
);

   logic [fis_pkg::CNT_W-1:0]   mem [0:fis_pkg::BUCKETS-1];
   logic [fis_pkg::BUCKETS-1:0] valid_ff;
   logic [fis_pkg::BUCKETS-1:0] valid_in;
   logic [fis_pkg::CNT_W-1:0]   rd_data_ff;
   logic                        rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- hdl/frame_interval_statistics.sv -----
// Frame interval statistics: top level with sequencer, scalar statistics and APB registers.
// Depends on fis_pkg, fis_ring_mem and fis_bucket_mem.
//
// Usage: items enter on the req_ stream. req_tuser carries the operation:
// frame swap timestamp, percentile query or histogram bucket read. Each item
// gives exactly one result on the rsp_ stream with the statistics after the
// item, the accepted flag in rsp_tuser and the query answer.
// A timestamp passes the states ST1 and ST2, and ST3 when it is recorded,
// before DONE; a bucket read passes BQ_RD and BQ_DATA before DONE.
// A percentile query runs a binary search over interval values in at most
// 27 passes; each pass scans the filled ring entries through the single
// read port of the ring memory.
// One item is in work at a time; req_tready is high while the sequencer idles.
// The result sits in an output register, so a new item is taken while a
// result waits; a result that cannot leave holds the sequencer in its done state.
// Reset clears all statistics, the histogram (via valid bits), the ring fill
// state and restores budget_ns to 16666667. Write budget_ns only when idle.
`timescale 1ns / 1ps
module frame_interval_statistics #(
   parameter int RING_DEPTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: timestamp_ns[62:0], quantile[79:63], bucket_index[82:80], zero pad
   input  logic [87:0]  req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: interval_ns[26:0], frames_recorded[58:27], frames_missed[90:59],
   // worst_interval_ns[117:91], interval_total_ns[181:118], answer[213:182], zero pad
   output logic [215:0] rsp_tdata,
   // tuser: accepted[0]
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int NW = AW + 1;
   localparam int PW = fis_pkg::Q_W + AW;
   localparam int IW = fis_pkg::IV_W;
   localparam int CW = fis_pkg::CNT_W;
   localparam logic [NW-1:0] DEPTH_N = NW'(RING_DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);

   fis_pkg::state_type state_ff, state_in;

   logic [fis_pkg::OP_W-1:0]    op_ff, op_in;
   logic [fis_pkg::STAMP_W-1:0] ts_ff, ts_in;
   logic [fis_pkg::Q_W-1:0]     q_ff, q_in;
   logic [fis_pkg::BIDX_W-1:0]  bidx_ff, bidx_in;
   logic [IW-1:0]               budget_ff, budget_in;
   logic [fis_pkg::STAMP_W-1:0] prev_ff, prev_in;
   logic                        ref_ff, ref_in;
   logic [IW-1:0]               last_ff, last_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               missed_ff, missed_in;
   logic [IW-1:0]               worst_ff, worst_in;
   logic [fis_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [AW-1:0]               wpos_ff, wpos_in;
   logic                        full_ff, full_in;
   logic [IW-1:0]               iv_ff, iv_in;
   logic                        ok_ff, ok_in;
   logic [fis_pkg::BIDX_W-1:0]  bkt_ff, bkt_in;
   logic [NW-1:0]               n_ff, n_in;
   logic [PW-1:0]               prod_ff, prod_in;
   logic [AW-1:0]               k_ff, k_in;
   logic [IW-1:0]               lo_ff, lo_in;
   logic [IW-1:0]               hi_ff, hi_in;
   logic [IW-1:0]               mid_ff, mid_in;
   logic [NW-1:0]               cnt_ff, cnt_in;
   logic [NW-1:0]               ptr_ff, ptr_in;
   logic                        rvld_ff, rvld_in;
   logic [CW-1:0]               ans_ff, ans_in;
   logic                        acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [215:0]                rsp_data_ff, rsp_data_in;
   logic                        rsp_user_ff, rsp_user_in;

   // memory ports
   logic                        ring_wr_en;
   logic [IW-1:0]               ring_rd_data;
   logic                        ring_rd_en;
   fis_pkg::bkt_wr_type         bkt_wr;
   logic [fis_pkg::BIDX_W-1:0]  bkt_rd_addr;
   logic [CW-1:0]               bkt_rd_data;

   // datapath temporaries
   logic [fis_pkg::STAMP_W:0]   diff;
   logic [fis_pkg::SUM_W:0]     sum_add;
   logic [IW+1:0]               two_iv;
   logic [IW+1:0]               three_budget;
   logic [PW:0]                 rank_full;
   logic [PW-16:0]              rank;
   logic [IW:0]                 mid_sum;
   logic [NW-1:0]               n_now;
   logic                        out_free;
   logic                        csr_wr;

   fis_ring_mem #(
      .DEPTH (RING_DEPTH),
      .WIDTH (IW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (wpos_ff),
      .wr_data (iv_ff),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (ring_rd_data)
   );

   fis_bucket_mem u_bkt (
      .clock   (clock),
      .reset   (reset),
      .wr      (bkt_wr),
      .rd_addr (bkt_rd_addr),
      .rd_data (bkt_rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == fis_pkg::CSR_BUDGET_ADDR) ? {5'd0, budget_ff} : 32'd0;

   assign req_tready = (state_ff == fis_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign n_now      = full_ff ? DEPTH_N : {1'b0, wpos_ff};

   assign diff         = {1'b0, ts_ff} - {1'b0, prev_ff};
   assign sum_add      = {1'b0, sum_ff} + {{(fis_pkg::SUM_W + 1 - IW){1'b0}}, iv_ff};
   assign two_iv       = {1'b0, iv_ff, 1'b0};
   assign three_budget = {2'b00, budget_ff} + {1'b0, budget_ff, 1'b0};
   assign rank_full    = {1'b0, prod_ff} + (PW + 1)'(32768);
   assign rank         = rank_full[PW:16];
   assign mid_sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign ring_rd_en   = (state_ff == fis_pkg::S_P_SCAN) && (ptr_ff < n_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ts_in        = ts_ff;
      q_in         = q_ff;
      bidx_in      = bidx_ff;
      budget_in    = budget_ff;
      prev_in      = prev_ff;
      ref_in       = ref_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      missed_in    = missed_ff;
      worst_in     = worst_ff;
      sum_in       = sum_ff;
      wpos_in      = wpos_ff;
      full_in      = full_ff;
      iv_in        = iv_ff;
      ok_in        = ok_ff;
      bkt_in       = bkt_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      rvld_in      = 1'b0;
      ans_in       = ans_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ring_wr_en   = 1'b0;
      bkt_wr       = '0;
      bkt_rd_addr  = bkt_ff;

      if (csr_wr && csr_paddr == fis_pkg::CSR_BUDGET_ADDR) begin
         budget_in = csr_pwdata[IW-1:0];
      end

      case (state_ff)
         fis_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               ts_in   = req_tdata[62:0];
               q_in    = req_tdata[79:63];
               bidx_in = req_tdata[82:80];
               ans_in  = '0;
               acc_in  = 1'b0;
               n_in    = n_now;
               case (req_tuser)
                  fis_pkg::OP_STAMP:  state_in = fis_pkg::S_ST1;
                  fis_pkg::OP_PCTL:   state_in = fis_pkg::S_P_MUL;
                  fis_pkg::OP_BUCKET: state_in = fis_pkg::S_BQ_RD;
                  default:            state_in = fis_pkg::S_DONE;
               endcase
            end
         end
         fis_pkg::S_ST1: begin
            prev_in = ts_ff;
            iv_in   = diff[IW-1:0];
            // positive interval of at most 100 ms
            ok_in   = ref_ff && !diff[fis_pkg::STAMP_W] && (diff != '0) &&
                      (diff[fis_pkg::STAMP_W-1:IW] == '0) &&
                      (diff[IW-1:0] <= fis_pkg::MAX_INTERVAL);
            ref_in  = 1'b1;
            state_in = fis_pkg::S_ST2;
         end
         fis_pkg::S_ST2: begin
            if (!ok_ff) begin
               state_in = fis_pkg::S_DONE;
            end else begin
               last_in  = iv_ff;
               sum_in   = sum_add[fis_pkg::SUM_W] ? '1 : sum_add[fis_pkg::SUM_W-1:0];
               count_in = fis_pkg::sat_inc(count_ff);
               if (iv_ff > worst_ff) begin
                  worst_in = iv_ff;
               end
               if (two_iv > three_budget) begin
                  missed_in = fis_pkg::sat_inc(missed_ff);
               end
               bkt_in      = fis_pkg::bucket_of(iv_ff);
               bkt_rd_addr = fis_pkg::bucket_of(iv_ff);
               ring_wr_en  = 1'b1;
               if (wpos_ff == LAST_POS) begin
                  wpos_in = '0;
                  full_in = 1'b1;
               end else begin
                  wpos_in = wpos_ff + 1'b1;
               end
               state_in = fis_pkg::S_ST3;
            end
         end
         fis_pkg::S_ST3: begin
            bkt_wr.en   = 1'b1;
            bkt_wr.addr = bkt_ff;
            bkt_wr.data = fis_pkg::sat_inc(bkt_rd_data);
            acc_in      = 1'b1;
            state_in    = fis_pkg::S_DONE;
         end
         fis_pkg::S_P_MUL: begin
            if (n_ff == '0) begin
               state_in = fis_pkg::S_DONE;
            end else begin
               prod_in  = PW'(q_ff * AW'(n_ff - 1'b1));
               state_in = fis_pkg::S_P_RANK;
            end
         end
         fis_pkg::S_P_RANK: begin
            // clamp rank to the last filled entry
            if (rank > (PW - 15)'(n_ff - 1'b1)) begin
               k_in = AW'(n_ff - 1'b1);
            end else begin
               k_in = rank[AW-1:0];
            end
            lo_in    = '0;
            hi_in    = '1;
            state_in = fis_pkg::S_P_PASS;
         end
         fis_pkg::S_P_PASS: begin
            if (lo_ff == hi_ff) begin
               ans_in   = {{(CW - IW){1'b0}}, lo_ff};
               state_in = fis_pkg::S_DONE;
            end else begin
               mid_in   = mid_sum[IW:1];
               cnt_in   = '0;
               ptr_in   = '0;
               state_in = fis_pkg::S_P_SCAN;
            end
         end
         fis_pkg::S_P_SCAN: begin
            // count entries not above mid, one read a cycle
            if (ring_rd_en) begin
               ptr_in  = ptr_ff + 1'b1;
               rvld_in = 1'b1;
            end
            if (rvld_ff && ring_rd_data <= mid_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (!ring_rd_en && !rvld_ff) begin
               state_in = fis_pkg::S_P_DECIDE;
            end
         end
         fis_pkg::S_P_DECIDE: begin
            if (cnt_ff > {1'b0, k_ff}) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = fis_pkg::S_P_PASS;
         end
         fis_pkg::S_BQ_RD: begin
            bkt_rd_addr = (bidx_ff < 3'(fis_pkg::BUCKETS)) ? bidx_ff : '0;
            state_in    = fis_pkg::S_BQ_DATA;
         end
         fis_pkg::S_BQ_DATA: begin
            ans_in   = (bidx_ff < 3'(fis_pkg::BUCKETS)) ? bkt_rd_data : '0;
            state_in = fis_pkg::S_DONE;
         end
         fis_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = acc_ff;
               rsp_data_in  = {2'b00, ans_ff, sum_ff, worst_ff, missed_ff, count_ff, last_ff};
               state_in     = fis_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fis_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fis_pkg::S_IDLE;
         budget_ff    <= fis_pkg::BUDGET_RESET;
         prev_ff      <= '0;
         ref_ff       <= 1'b0;
         last_ff      <= '0;
         count_ff     <= '0;
         missed_ff    <= '0;
         worst_ff     <= '0;
         sum_ff       <= '0;
         wpos_ff      <= '0;
         full_ff      <= 1'b0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         budget_ff    <= budget_in;
         prev_ff      <= prev_in;
         ref_ff       <= ref_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         missed_ff    <= missed_in;
         worst_ff     <= worst_in;
         sum_ff       <= sum_in;
         wpos_ff      <= wpos_in;
         full_ff      <= full_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ts_ff       <= ts_in;
      q_ff        <= q_in;
      bidx_ff     <= bidx_in;
      iv_ff       <= iv_in;
      ok_ff       <= ok_in;
      bkt_ff      <= bkt_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      k_ff        <= k_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      cnt_ff      <= cnt_in;
      ptr_ff      <= ptr_in;
      ans_ff      <= ans_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

// ----- hdl/fis_checker.sv -----
// Port-level checks for frame_interval_statistics, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module fis_checker (
   input logic         clock,
   input logic         reset,
   input logic [215:0] rsp_tdata,
   input logic [0:0]   rsp_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // hold a result until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   // a recorded interval is nonzero, within the worst and counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[26:0] != 27'd0 && rsp_tdata[26:0] <= rsp_tdata[117:91] &&
         rsp_tdata[58:27] != 32'd0)
      else $error("recorded item has inconsistent statistics");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[117:91] <= 27'd100000000 &&
         rsp_tdata[90:59] <= rsp_tdata[58:27])
      else $error("worst interval or missed count out of range");

endmodule

bind frame_interval_statistics fis_checker u_fis_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
